>>> hw/rtl/mfmt_pkg.sv
// Package with shared constants and types of the multiturn feedback tracker.
`default_nettype none

package mfmt_pkg;

   localparam int MOTORS_PER_BUS  = 4;
   localparam int NUM_BUSES       = 2;
   localparam int COUNTS_PER_TURN = 8192;

   localparam int NUM_SLOTS = MOTORS_PER_BUS * NUM_BUSES;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int SEL_W     = 3;
   localparam int SUMIDX_W  = 16;

   localparam int ID_W      = 11;
   localparam int ANGLE_W   = 13;
   localparam int SPEED_W   = 16;
   localparam int CURRENT_W = 16;
   localparam int TEMP_W    = 8;
   localparam int FRAMES_W  = 8;
   localparam int TURN_W    = 18;
   localparam int TOTAL_W   = 32;

   localparam int CPT_W   = $clog2(COUNTS_PER_TURN + 1);
   localparam int DELTA_W = ((ANGLE_W + 1) > (CPT_W + 1)) ? (ANGLE_W + 1) : (CPT_W + 1);
   localparam int SUM_W   = ((TURN_W + CPT_W + 2) > (TOTAL_W + 1)) ?
                            (TURN_W + CPT_W + 2) : (TOTAL_W + 1);

   localparam logic signed [DELTA_W-1:0] HALF_TURN = DELTA_W'(COUNTS_PER_TURN / 2);
   localparam logic signed [DELTA_W-1:0] NEG_HALF_TURN = -HALF_TURN;
   localparam logic signed [SUM_W-1:0]   TURN_SCALE = SUM_W'(COUNTS_PER_TURN);

   localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W - 1){1'b1}}};
   localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W - 1){1'b0}}};

   localparam logic signed [TOTAL_W-1:0] TOTAL_MAX32 = {1'b0, {(TOTAL_W - 1){1'b1}}};
   localparam logic signed [TOTAL_W-1:0] TOTAL_MIN32 = {1'b1, {(TOTAL_W - 1){1'b0}}};
   localparam logic signed [SUM_W-1:0]   TOTAL_MAX   = SUM_W'(TOTAL_MAX32);
   localparam logic signed [SUM_W-1:0]   TOTAL_MIN   = SUM_W'(TOTAL_MIN32);

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_FRAMES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ID      = 1'd1;

   localparam logic [FRAMES_W-1:0] CALIB_RESET   = 8'd51;
   localparam logic [ID_W-1:0]     BASE_ID_RESET = 11'h201;

   typedef struct packed {
      logic [ANGLE_W-1:0]       prev_angle;
      logic signed [TURN_W-1:0] turn_count;
      logic [ANGLE_W-1:0]       zero_offset;
      logic [FRAMES_W-1:0]      frames_seen;
   } entry_type;

   typedef struct packed {
      logic [ANGLE_W-1:0]          angle;
      logic signed [SPEED_W-1:0]   speed;
      logic signed [CURRENT_W-1:0] current;
      logic [TEMP_W-1:0]           temp;
   } fields_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

>>> hw/rtl/motor_feedback_multiturn_tracker.sv
// Top level of the multiturn tracker for motor feedback frames.
//
//   Channel   Direction  Handshake               Carries
//   req_      in         req_valid / req_ready   one received feedback frame
//   rsp_      out        rsp_valid / rsp_ready   decoded fields and total angle
//   csr_      in         csr_valid / csr_ready   register index and write data
//
// One item is accepted per cycle while req_ready is high; its result is registered in s1, s2 and out.
// The per-motor state lives in an eight-entry RAM read at the accepting edge and re-read
// while the first stage holds; the entry written by the previous item is forwarded from a register.
// Reset clears the per-entry valid bits, so every entry reads as zero at once.
// When rsp_ready is low the three stages fill, and req_ready falls when all are full.
`default_nettype none

module motor_feedback_multiturn_tracker import mfmt_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        reset,

   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_bus,
   input  wire logic [ID_W-1:0]             req_frame_id,
   input  wire logic [ANGLE_W-1:0]          req_angle_word,
   input  wire logic signed [SPEED_W-1:0]   req_speed_word,
   input  wire logic signed [CURRENT_W-1:0] req_current_word,
   input  wire logic [TEMP_W-1:0]           req_temp_byte,

   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_hit,
   output logic [SEL_W-1:0]                 rsp_motor_sel,
   output logic                             rsp_calibrating,
   output logic [ANGLE_W-1:0]               rsp_angle_out,
   output logic signed [SPEED_W-1:0]        rsp_speed_out,
   output logic signed [CURRENT_W-1:0]      rsp_current_out,
   output logic [TEMP_W-1:0]                rsp_temp_out,
   output logic signed [TOTAL_W-1:0]        rsp_total_out,

   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [CSR_DATA_W-1:0]       csr_wdata
);

   logic [FRAMES_W-1:0] calib_frames_ff, calib_frames_in;
   logic [ID_W-1:0]     base_id_ff, base_id_in;

   logic                out_en, s2_en, s1_en, req_fire;

   logic [ID_W-1:0]     req_off;
   logic [SUMIDX_W-1:0] req_slot_sum;
   logic                req_hit;
   fields_type          req_fields;

   logic                s1_valid_ff, s1_valid_in;
   logic                s1_hit_ff;
   logic [SLOT_W-1:0]   s1_slot_ff;
   logic [SEL_W-1:0]    s1_sel_ff;
   fields_type          s1_fields_ff;

   logic [SLOT_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_data;
   logic                ram_wr_en;

   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic                 fwd_valid_ff, fwd_valid_in;
   logic [SLOT_W-1:0]    fwd_slot_ff;
   entry_type            fwd_data_ff;

   entry_type                 cur_entry, new_entry;
   logic                      s1_calib;
   logic signed [DELTA_W-1:0] delta;
   logic signed [TURN_W-1:0]  turn_next;

   logic                      s2_valid_ff, s2_valid_in;
   logic                      s2_hit_ff;
   logic [SEL_W-1:0]          s2_sel_ff;
   logic                      s2_calib_ff;
   fields_type                s2_fields_ff;
   logic signed [TURN_W-1:0]  s2_turn_ff;
   logic [ANGLE_W-1:0]        s2_offset_ff;

   logic signed [SUM_W-1:0]   turn_ext, product, sum;
   logic signed [TOTAL_W-1:0] total_sat;

   logic                      out_valid_ff, out_valid_in;
   logic                      out_hit_ff;
   logic [SEL_W-1:0]          out_sel_ff;
   logic                      out_calib_ff;
   fields_type                out_fields_ff;
   logic signed [TOTAL_W-1:0] out_total_ff;

   assign csr_ready = 1'b1;

   always_comb begin
      calib_frames_in = calib_frames_ff;
      base_id_in      = base_id_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CALIB_FRAMES: calib_frames_in = csr_wdata[FRAMES_W-1:0];
            CSR_BASE_ID:      base_id_in      = csr_wdata[ID_W-1:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_frames_ff <= CALIB_RESET;
         base_id_ff      <= BASE_ID_RESET;
      end else begin
         calib_frames_ff <= calib_frames_in;
         base_id_ff      <= base_id_in;
      end
   end

   assign out_en    = !out_valid_ff || rsp_ready;
   assign s2_en     = !s2_valid_ff || out_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_ready = s1_en;
   assign req_fire  = req_valid && s1_en;

   assign req_off      = req_frame_id - base_id_ff;
   assign req_slot_sum = SUMIDX_W'(req_bus) * SUMIDX_W'(MOTORS_PER_BUS) + SUMIDX_W'(req_off);
   assign req_hit      = (req_frame_id >= base_id_ff) && (32'(req_off) < MOTORS_PER_BUS) &&
                         (32'(req_bus) < NUM_BUSES) && (32'(req_slot_sum) < NUM_SLOTS);
   assign req_fields   = '{angle: req_angle_word, speed: req_speed_word,
                           current: req_current_word, temp: req_temp_byte};

   assign s1_valid_in = req_fire ? 1'b1 : (s2_en ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_fire) begin
         s1_hit_ff    <= req_hit;
         s1_slot_ff   <= req_slot_sum[SLOT_W-1:0];
         s1_sel_ff    <= req_slot_sum[SEL_W-1:0];
         s1_fields_ff <= req_fields;
      end
   end

   assign ram_rd_addr = req_fire ? req_slot_sum[SLOT_W-1:0] : s1_slot_ff;
   assign ram_wr_en   = s1_valid_ff && s2_en && s1_hit_ff;

   mfmt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SLOTS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_slot_ff),
      .wr_data (new_entry),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      if (fwd_valid_ff && (fwd_slot_ff == s1_slot_ff)) begin
         cur_entry = fwd_data_ff;
      end else if (valid_ff[s1_slot_ff]) begin
         cur_entry = entry_type'(ram_rd_data);
      end else begin
         cur_entry = '0;
      end

      s1_calib = cur_entry.frames_seen < calib_frames_ff;
      delta    = $signed(DELTA_W'(s1_fields_ff.angle)) - $signed(DELTA_W'(cur_entry.prev_angle));

      turn_next = cur_entry.turn_count;
      if (!s1_calib) begin
         if (delta > HALF_TURN) begin
            if (cur_entry.turn_count != TURN_MIN) begin
               turn_next = cur_entry.turn_count - TURN_W'(1);
            end
         end else if (delta < NEG_HALF_TURN) begin
            if (cur_entry.turn_count != TURN_MAX) begin
               turn_next = cur_entry.turn_count + TURN_W'(1);
            end
         end
      end

      new_entry.prev_angle  = s1_fields_ff.angle;
      new_entry.turn_count  = turn_next;
      new_entry.zero_offset = s1_calib ? s1_fields_ff.angle : cur_entry.zero_offset;
      new_entry.frames_seen = (&cur_entry.frames_seen) ? cur_entry.frames_seen :
                              cur_entry.frames_seen + FRAMES_W'(1);
   end

   always_comb begin
      valid_in = valid_ff;
      if (ram_wr_en) begin
         valid_in[s1_slot_ff] = 1'b1;
      end
   end

   assign fwd_valid_in = ram_wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         fwd_valid_ff <= fwd_valid_in;
      end
      if (ram_wr_en) begin
         fwd_slot_ff <= s1_slot_ff;
         fwd_data_ff <= new_entry;
      end
   end

   assign s2_valid_in = (s1_valid_ff && s2_en) ? 1'b1 : (out_en ? 1'b0 : s2_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
      if (s1_valid_ff && s2_en) begin
         s2_hit_ff    <= s1_hit_ff;
         s2_sel_ff    <= s1_sel_ff;
         s2_calib_ff  <= s1_calib;
         s2_fields_ff <= s1_fields_ff;
         s2_turn_ff   <= new_entry.turn_count;
         s2_offset_ff <= new_entry.zero_offset;
      end
   end

   always_comb begin
      turn_ext = SUM_W'(s2_turn_ff);
      product  = turn_ext * TURN_SCALE;
      sum      = product + $signed(SUM_W'(s2_fields_ff.angle)) - $signed(SUM_W'(s2_offset_ff));
      if (sum > TOTAL_MAX) begin
         total_sat = TOTAL_MAX32;
      end else if (sum < TOTAL_MIN) begin
         total_sat = TOTAL_MIN32;
      end else begin
         total_sat = sum[TOTAL_W-1:0];
      end
   end

   assign out_valid_in = (s2_valid_ff && out_en) ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (s2_valid_ff && out_en) begin
         out_hit_ff    <= s2_hit_ff;
         out_sel_ff    <= s2_hit_ff ? s2_sel_ff : '0;
         out_calib_ff  <= s2_hit_ff && s2_calib_ff;
         out_fields_ff <= s2_hit_ff ? s2_fields_ff : '0;
         out_total_ff  <= s2_hit_ff ? total_sat : '0;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_hit         = out_hit_ff;
   assign rsp_motor_sel   = out_sel_ff;
   assign rsp_calibrating = out_calib_ff;
   assign rsp_angle_out   = out_fields_ff.angle;
   assign rsp_speed_out   = out_fields_ff.speed;
   assign rsp_current_out = out_fields_ff.current;
   assign rsp_temp_out    = out_fields_ff.temp;
   assign rsp_total_out   = out_total_ff;

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_total_out == '0 && !rsp_calibrating))
      else $error("A missed frame carries a nonzero total or calibration flag.");

   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> valid_ff[$past(s1_slot_ff)])
      else $error("A written state entry is not marked valid.");

   a_fwd_entry_valid: assert property (@(posedge clock) disable iff (reset)
      fwd_valid_ff |-> valid_ff[fwd_slot_ff])
      else $error("The forwarded entry is not marked valid.");

   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("An accepted item did not reach the first stage.");

endmodule

`default_nettype wire

>>> hw/rtl/mfmt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module mfmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> verif/motor_feedback_multiturn_tracker_test.sv
// Self-checking testbench of the multiturn feedback tracker: directed table, random phases, turn sweep.
`timescale 1ns / 100ps

module motor_feedback_multiturn_tracker_test;
   import mfmt_pkg::*;

   localparam int  ITEMS_PER_PHASE = 90;
   localparam int  RANDOM_PHASES   = 8;
   localparam int  HOLD_CYCLES     = 64;
   localparam int  SWEEP_TURNS     = 12;
   localparam longint LIMIT_NS     = 2_000_000;

   typedef struct packed {
      logic                        bus;
      logic [ID_W-1:0]             frame_id;
      logic [ANGLE_W-1:0]          angle;
      logic signed [SPEED_W-1:0]   speed;
      logic signed [CURRENT_W-1:0] current;
      logic [TEMP_W-1:0]           temp;
   } feedback_frame_type;

   typedef struct packed {
      logic                        hit;
      logic [SEL_W-1:0]            motor_sel;
      logic                        calibrating;
      logic [ANGLE_W-1:0]          angle;
      logic signed [SPEED_W-1:0]   speed;
      logic signed [CURRENT_W-1:0] current;
      logic [TEMP_W-1:0]           temp;
      logic signed [TOTAL_W-1:0]   total;
   } motor_report_type;

   typedef enum {STEP_FRAME, STEP_SETTING} step_kind_type;
   typedef enum {BY_PREDICTOR, AS_MISS, AS_HIT} check_mode_type;

   typedef struct {
      step_kind_type       kind;
      feedback_frame_type  frame;
      check_mode_type      mode;
      motor_report_type    fixed;
      logic [FRAMES_W-1:0] calib;
      logic [ID_W-1:0]     base;
   } directed_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_bus = 1'b0;
   logic [ID_W-1:0]             req_frame_id = '0;
   logic [ANGLE_W-1:0]          req_angle_word = '0;
   logic signed [SPEED_W-1:0]   req_speed_word = '0;
   logic signed [CURRENT_W-1:0] req_current_word = '0;
   logic [TEMP_W-1:0]           req_temp_byte = '0;

   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic                        rsp_hit;
   logic [SEL_W-1:0]            rsp_motor_sel;
   logic                        rsp_calibrating;
   logic [ANGLE_W-1:0]          rsp_angle_out;
   logic signed [SPEED_W-1:0]   rsp_speed_out;
   logic signed [CURRENT_W-1:0] rsp_current_out;
   logic [TEMP_W-1:0]           rsp_temp_out;
   logic signed [TOTAL_W-1:0]   rsp_total_out;

   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index = CSR_CALIB_FRAMES;
   logic [CSR_DATA_W-1:0]       csr_wdata = '0;

   logic             req_fixed_on = 1'b0;
   motor_report_type req_fixed = '0;

   bit  quiet = 1'b0;
   bit  send_idle_on = 1'b1;
   bit  rsp_idle_on = 1'b1;
   bit  long_hold_asked = 1'b0;
   int  failures = 0;
   int  results_checked = 0;
   logic [ID_W-1:0] base_now = BASE_ID_RESET;

   logic [FRAMES_W-1:0]      calib_setting;
   logic [ID_W-1:0]          base_setting;
   logic [ANGLE_W-1:0]       prior_angle [NUM_SLOTS];
   logic signed [TURN_W-1:0] revolutions [NUM_SLOTS];
   logic [ANGLE_W-1:0]       zero_angle [NUM_SLOTS];
   logic [FRAMES_W-1:0]      seen_count [NUM_SLOTS];

   motor_report_type  pending_reports [$];
   directed_step_type directed_steps [$];

   motor_feedback_multiturn_tracker dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_bus          (req_bus),
      .req_frame_id     (req_frame_id),
      .req_angle_word   (req_angle_word),
      .req_speed_word   (req_speed_word),
      .req_current_word (req_current_word),
      .req_temp_byte    (req_temp_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_motor_sel    (rsp_motor_sel),
      .rsp_calibrating  (rsp_calibrating),
      .rsp_angle_out    (rsp_angle_out),
      .rsp_speed_out    (rsp_speed_out),
      .rsp_current_out  (rsp_current_out),
      .rsp_temp_out     (rsp_temp_out),
      .rsp_total_out    (rsp_total_out),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic motor_report_type track_frame(input feedback_frame_type f);
      motor_report_type r;
      int     motor_index;
      int     slot;
      logic   calib;
      int     delta;
      longint sum;
      r = '0;
      motor_index = int'(f.frame_id) - int'(base_setting);
      if (motor_index < 0 || int'(f.bus) >= NUM_BUSES || motor_index >= MOTORS_PER_BUS) begin
         return r;
      end
      slot = int'(f.bus) * MOTORS_PER_BUS + motor_index;
      if (slot >= NUM_SLOTS) begin
         return r;
      end
      calib = (seen_count[slot] < calib_setting);
      if (seen_count[slot] != {FRAMES_W{1'b1}}) begin
         seen_count[slot] = seen_count[slot] + 1'b1;
      end
      if (calib) begin
         zero_angle[slot] = f.angle;
      end else begin
         delta = int'(f.angle) - int'(prior_angle[slot]);
         if (delta > COUNTS_PER_TURN / 2) begin
            if (revolutions[slot] != TURN_MIN) revolutions[slot] = revolutions[slot] - 1'b1;
         end else if (delta < -(COUNTS_PER_TURN / 2)) begin
            if (revolutions[slot] != TURN_MAX) revolutions[slot] = revolutions[slot] + 1'b1;
         end
      end
      prior_angle[slot] = f.angle;
      sum = longint'(revolutions[slot]) * COUNTS_PER_TURN
            + longint'(f.angle) - longint'(zero_angle[slot]);
      if (sum > longint'(TOTAL_MAX32)) sum = longint'(TOTAL_MAX32);
      if (sum < longint'(TOTAL_MIN32)) sum = longint'(TOTAL_MIN32);
      r.hit         = 1'b1;
      r.motor_sel   = SEL_W'(slot);
      r.calibrating = calib;
      r.angle       = f.angle;
      r.speed       = f.speed;
      r.current     = f.current;
      r.temp        = f.temp;
      r.total       = sum[TOTAL_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      failures++;
      $display("%0t ns: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic signed [63:0] got,
                              input logic signed [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("item %0d %s: got %0d, want %0d",
                                   results_checked, name, got, want));
      end
   endtask

   always @(posedge clock) begin
      motor_report_type   want;
      feedback_frame_type f;
      if (reset) begin
         calib_setting = CALIB_RESET;
         base_setting  = BASE_ID_RESET;
         for (int k = 0; k < NUM_SLOTS; k++) begin
            prior_angle[k]  = '0;
            revolutions[k]  = '0;
            zero_angle[k]   = '0;
            seen_count[k]   = '0;
         end
         pending_reports.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CALIB_FRAMES: calib_setting = csr_wdata[FRAMES_W-1:0];
               CSR_BASE_ID:      base_setting = csr_wdata[ID_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               report_mismatch("result item arrived with nothing pending");
            end else begin
               want = pending_reports.pop_front();
               check_field("hit", rsp_hit, want.hit);
               check_field("motor_sel", rsp_motor_sel, want.motor_sel);
               check_field("calibrating", rsp_calibrating, want.calibrating);
               check_field("angle_out", rsp_angle_out, want.angle);
               check_field("speed_out", rsp_speed_out, want.speed);
               check_field("current_out", rsp_current_out, want.current);
               check_field("temp_out", rsp_temp_out, want.temp);
               check_field("total_out", rsp_total_out, want.total);
            end
            results_checked++;
         end
         if (req_valid && req_ready) begin
            f.bus      = req_bus;
            f.frame_id = req_frame_id;
            f.angle    = req_angle_word;
            f.speed    = req_speed_word;
            f.current  = req_current_word;
            f.temp     = req_temp_byte;
            want = track_frame(f);
            if (req_fixed_on) pending_reports.push_back(req_fixed);
            else pending_reports.push_back(want);
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_asked) begin
            long_hold_asked = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!quiet && rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic void add_frame(input logic bus, input int id, input int angle,
                                     input int speed, input int current, input int temp,
                                     input check_mode_type mode, input int sel,
                                     input logic calib, input int total);
      directed_step_type s;
      s.kind           = STEP_FRAME;
      s.mode           = mode;
      s.calib          = '0;
      s.base           = '0;
      s.frame.bus      = bus;
      s.frame.frame_id = ID_W'(id);
      s.frame.angle    = ANGLE_W'(angle);
      s.frame.speed    = SPEED_W'(speed);
      s.frame.current  = CURRENT_W'(current);
      s.frame.temp     = TEMP_W'(temp);
      s.fixed          = '0;
      if (mode == AS_HIT) begin
         s.fixed.hit         = 1'b1;
         s.fixed.motor_sel   = SEL_W'(sel);
         s.fixed.calibrating = calib;
         s.fixed.angle       = s.frame.angle;
         s.fixed.speed       = s.frame.speed;
         s.fixed.current     = s.frame.current;
         s.fixed.temp        = s.frame.temp;
         s.fixed.total       = TOTAL_W'(total);
      end
      directed_steps.push_back(s);
   endfunction

   function automatic void add_setting(input int calib, input int base);
      directed_step_type s;
      s.kind  = STEP_SETTING;
      s.mode  = BY_PREDICTOR;
      s.frame = '0;
      s.fixed = '0;
      s.calib = FRAMES_W'(calib);
      s.base  = ID_W'(base);
      directed_steps.push_back(s);
   endfunction

   function automatic feedback_frame_type random_frame(input logic [ID_W-1:0] base);
      feedback_frame_type f;
      if ($urandom_range(0, 9) < 8) f.frame_id = ID_W'(int'(base) + $urandom_range(0, 3));
      else f.frame_id = ID_W'($urandom_range(0, 2047));
      f.bus = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: f.angle = ANGLE_W'($urandom_range(0, 8191));
         1: f.angle = ANGLE_W'($urandom_range(0, 40));
         2: f.angle = ANGLE_W'($urandom_range(8150, 8191));
         default: f.angle = ANGLE_W'($urandom_range(4040, 4150));
      endcase
      f.speed   = SPEED_W'($urandom);
      f.current = CURRENT_W'($urandom);
      f.temp    = TEMP_W'($urandom);
      return f;
   endfunction

   task automatic send_frame(input feedback_frame_type f, input logic fixed_on,
                             input motor_report_type fixed);
      req_valid        <= 1'b1;
      req_bus          <= f.bus;
      req_frame_id     <= f.frame_id;
      req_angle_word   <= f.angle;
      req_speed_word   <= f.speed;
      req_current_word <= f.current;
      req_temp_byte    <= f.temp;
      req_fixed_on     <= fixed_on;
      req_fixed        <= fixed;
      do @(posedge clock); while (!req_ready);
      if (!quiet && send_idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic wait_for_results;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_reports.size() != 0);
   endtask

   task automatic write_settings(input logic [FRAMES_W-1:0] calib, input logic [ID_W-1:0] base);
      csr_valid <= 1'b1;
      csr_index <= CSR_CALIB_FRAMES;
      csr_wdata <= CSR_DATA_W'(calib);
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_BASE_ID;
      csr_wdata <= CSR_DATA_W'(base);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      base_now = base;
   endtask

   task automatic sweep_slot(input logic bus, input logic [ID_W-1:0] id, input bit forward);
      feedback_frame_type f;
      f.bus      = bus;
      f.frame_id = id;
      for (int t = 0; t < SWEEP_TURNS; t++) begin
         for (int k = 0; k < 3; k++) begin
            f.angle   = ANGLE_W'(forward ? k * 3000 : 6000 - k * 3000);
            f.speed   = SPEED_W'($urandom);
            f.current = CURRENT_W'($urandom);
            f.temp    = TEMP_W'($urandom);
            send_frame(f, 1'b0, '0);
         end
      end
   endtask

   initial begin
      logic [FRAMES_W-1:0] calib_pick;
      logic [ID_W-1:0]     base_pick;

      add_frame(1'b0, 513, 100, 1234, -5, 40, AS_HIT, 0, 1'b1, 0);
      add_frame(1'b0, 512, 5, 1, 1, 1, AS_MISS, 0, 1'b0, 0);
      add_frame(1'b0, 517, 5, 1, 1, 1, AS_MISS, 0, 1'b0, 0);
      add_frame(1'b1, 516, 8191, -32768, 32767, 255, AS_HIT, 7, 1'b1, 0);
      add_frame(1'b1, 2047, 0, 32767, -32768, 0, AS_MISS, 0, 1'b0, 0);
      add_frame(1'b0, 0, 4096, -1, -1, 255, AS_MISS, 0, 1'b0, 0);
      add_frame(1'b1, 514, 4000, 0, 0, 128, AS_HIT, 5, 1'b1, 0);
      add_setting(0, 0);
      add_frame(1'b0, 0, 100, 10, 20, 30, BY_PREDICTOR, 0, 1'b0, 0);
      add_frame(1'b0, 0, 4196, 10, 20, 30, BY_PREDICTOR, 0, 1'b0, 0);
      add_frame(1'b0, 0, 8191, 10, 20, 30, BY_PREDICTOR, 0, 1'b0, 0);
      add_frame(1'b0, 0, 0, 10, 20, 30, BY_PREDICTOR, 0, 1'b0, 0);
      add_frame(1'b0, 0, 4097, 10, 20, 30, BY_PREDICTOR, 0, 1'b0, 0);
      add_frame(1'b0, 0, 1, 10, 20, 30, BY_PREDICTOR, 0, 1'b0, 0);
      add_frame(1'b1, 3, 5, -100, 100, 60, BY_PREDICTOR, 0, 1'b0, 0);
      add_setting(255, 2047);
      add_frame(1'b1, 2047, 77, 5, 6, 7, AS_HIT, 4, 1'b1, 0);
      add_frame(1'b0, 2046, 77, 5, 6, 7, AS_MISS, 0, 1'b0, 0);
      add_frame(1'b0, 0, 77, 5, 6, 7, AS_MISS, 0, 1'b0, 0);
      add_setting(51, 513);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_SETTING) begin
            wait_for_results();
            write_settings(directed_steps[i].calib, directed_steps[i].base);
         end else begin
            send_frame(directed_steps[i].frame, directed_steps[i].mode != BY_PREDICTOR,
                       directed_steps[i].fixed);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin calib_pick = 8'd0;   base_pick = 11'd0;    end
            1: begin calib_pick = 8'd255; base_pick = 11'd2047; end
            2: begin calib_pick = 8'd2;   base_pick = 11'd513;  end
            4: begin calib_pick = 8'd5;   base_pick = 11'd2044; end
            default: begin
               calib_pick = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(0, 12));
               base_pick  = ID_W'($urandom_range(0, 2047));
            end
         endcase
         wait_for_results();
         write_settings(calib_pick, base_pick);
         send_idle_on = (phase % 3 != 1);
         rsp_idle_on  = (phase % 4 != 2);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (phase == 1 && i == 20) long_hold_asked = 1'b1;
            if (phase == 4 && i == 50) wait_for_results();
            send_frame(random_frame(base_now), 1'b0, '0);
         end
      end

      wait_for_results();
      write_settings(8'd2, 11'd513);
      quiet = 1'b1;
      sweep_slot(1'b0, 11'd514, 1'b0);
      sweep_slot(1'b1, 11'd515, 1'b1);

      wait_for_results();
      repeat (8) @(posedge clock);
      if (pending_reports.size() != 0) begin
         report_mismatch($sformatf("%0d result items never arrived", pending_reports.size()));
      end
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #(LIMIT_NS);
      $display("FAIL");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/mfmt_pkg.sv
hw/rtl/mfmt_ram.sv
hw/rtl/motor_feedback_multiturn_tracker.sv
verif/motor_feedback_multiturn_tracker_test.sv
